// ===== hdl/lkv_pkg.sv =====
package lkv_pkg;

  // Default sizes of the store, handed to the top level as parameter defaults.
  localparam int unsigned MaxLayersDef  = 4;
  localparam int unsigned MaxHeadsDef   = 4;
  localparam int unsigned MaxTokensDef  = 256;
  localparam int unsigned MaxHeadDimDef = 64;

  // Fixed field widths of the stream beats.
  localparam int unsigned CmdW     = 2;
  localparam int unsigned LayerW   = 2;
  localparam int unsigned FillW    = 9;
  localparam int unsigned PosW     = 8;
  localparam int unsigned HeadW    = 2;
  localparam int unsigned ElemW    = 6;
  localparam int unsigned WordW    = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned InPadW   = InDataW - (LayerW + FillW + PosW + HeadW + ElemW
                                                + 2 * WordW + FillW);
  localparam int unsigned OutPadW  = OutDataW - (2 * WordW + 2 * FillW);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Depth of the queue between front and back end.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND   = 2'd0,
    CMD_READ     = 2'd1,
    CMD_TRUNCATE = 2'd2,
    CMD_QUERY    = 2'd3
  } lkv_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_LAYER  = 3'd1,
    ST_CAPACITY   = 3'd2,
    ST_BAD_INDEX  = 3'd3,
    ST_TRUNC_LONG = 3'd4
  } lkv_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LAYERS   = 2'd0,
    CFG_ACTIVE_HEADS    = 2'd1,
    CFG_ACTIVE_HEAD_DIM = 2'd2,
    CFG_TOKEN_CAPACITY  = 2'd3
  } lkv_cfg_idx_e;

  typedef enum logic {
    BS_IDLE   = 1'b0,
    BS_FINISH = 1'b1
  } lkv_bstate_e;

  typedef struct packed {
    logic [2:0] layers;
    logic [2:0] heads;
    logic [6:0] head_dim;
    logic [8:0] capacity;
  } lkv_cfg_t;

  localparam logic [2:0] CfgLayersRst   = 3'd4;
  localparam logic [2:0] CfgHeadsRst    = 3'd4;
  localparam logic [6:0] CfgHeadDimRst  = 7'd64;
  localparam logic [8:0] CfgCapacityRst = 9'd256;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    lkv_cmd_e              cmd;
    logic [LayerW-1:0]     layer;
    logic [HeadW-1:0]      head;
    logic [ElemW-1:0]      element;
    logic [PosW-1:0]       position;
    logic [FillW-1:0]      block;
    logic [FillW-1:0]      target;
    logic [WordW-1:0]      key;
    logic [WordW-1:0]      value;
    logic                  block_end;
    logic                  layer_ok;
    logic                  lane_ok;
    logic                  pos_in_block;
  } lkv_item_t;

endpackage

// ===== hdl/lkv_ram.sv =====
module lkv_ram #(
  parameter int unsigned      Width = 32,
  parameter longint unsigned  Depth = 64,
  parameter int unsigned      AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port: write or registered read at one address per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lkv_queue.sv =====
module lkv_queue
  import lkv_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lkv_item_t item_i,
  output logic      full_o,
  output logic      valid_o,
  output lkv_item_t item_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  lkv_item_t         entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

// ===== hdl/lkv_front.sv =====
module lkv_front
  import lkv_pkg::*;
#(
  parameter int unsigned MaxLayers  = MaxLayersDef,
  parameter int unsigned MaxHeads   = MaxHeadsDef,
  parameter int unsigned MaxHeadDim = MaxHeadDimDef
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InDataW-1:0] in_data_i,
  input  logic [CmdW-1:0]    in_user_i,
  input  logic               in_last_i,
  input  lkv_cfg_t           cfg_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output lkv_item_t          item_o
);

  logic [LayerW-1:0] layer;
  logic [FillW-1:0]  block;
  logic [PosW-1:0]   position;
  logic [HeadW-1:0]  head;
  logic [ElemW-1:0]  element;

  // Unpack the input beat, lowest field first.
  assign layer    = in_data_i[1:0];
  assign block    = in_data_i[10:2];
  assign position = in_data_i[18:11];
  assign head     = in_data_i[20:19];
  assign element  = in_data_i[26:21];

  // A beat is taken whenever the queue has room.
  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Classify the item against the active configuration.
  always_comb begin
    item_o              = '0;
    item_o.cmd          = lkv_cmd_e'(in_user_i);
    item_o.layer        = layer;
    item_o.head         = head;
    item_o.element      = element;
    item_o.position     = position;
    item_o.block        = block;
    item_o.target       = in_data_i[99:91];
    item_o.key          = in_data_i[58:27];
    item_o.value        = in_data_i[90:59];
    item_o.block_end    = in_last_i;
    item_o.layer_ok     = (32'(layer) < 32'(cfg_i.layers)) && (32'(layer) < 32'(MaxLayers));
    item_o.lane_ok      = (32'(head) < 32'(cfg_i.heads)) && (32'(head) < 32'(MaxHeads))
                          && (32'(element) < 32'(cfg_i.head_dim))
                          && (32'(element) < 32'(MaxHeadDim));
    item_o.pos_in_block = ({1'b0, position} < block);
  end

endmodule

// ===== hdl/lkv_back.sv =====
module lkv_back
  import lkv_pkg::*;
#(
  parameter int unsigned MaxLayers  = MaxLayersDef,
  parameter int unsigned MaxHeads   = MaxHeadsDef,
  parameter int unsigned MaxTokens  = MaxTokensDef,
  parameter int unsigned MaxHeadDim = MaxHeadDimDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkv_cfg_t            cfg_i,
  input  logic                cfg_layers_wr_i,
  input  logic                item_valid_i,
  input  lkv_item_t           item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  out_status_o,
  output logic [WordW-1:0]    out_key_o,
  output logic [WordW-1:0]    out_value_o,
  output logic [FillW-1:0]    out_lfill_o,
  output logic [FillW-1:0]    out_min_o
);

  localparam int unsigned     LayerIdxW = (MaxLayers > 1) ? $clog2(MaxLayers) : 1;
  localparam int unsigned     SlotW     = (MaxTokens > 1) ? $clog2(MaxTokens) : 1;
  localparam longint unsigned MemDepth  = longint'(MaxLayers) * longint'(MaxHeads)
                                          * longint'(MaxTokens) * longint'(MaxHeadDim);
  localparam int unsigned     AddrW     = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam logic [LayerIdxW-1:0] LastIdx = LayerIdxW'(MaxLayers - 1);

  lkv_bstate_e          state_q, state_d;
  logic [FillW-1:0]     fill_q [MaxLayers];
  logic [FillW-1:0]     min_q;
  logic                 dirty_q;
  logic                 busy_q;
  logic [LayerIdxW-1:0] idx_q;
  logic [FillW-1:0]     acc_q;
  logic [FillW-1:0]     acc_next;

  lkv_status_e          pend_status_q;
  logic [FillW-1:0]     pend_lfill_q;
  logic                 pend_read_q;

  logic                 out_valid_q;
  lkv_status_e          out_status_q;
  logic [WordW-1:0]     out_key_q;
  logic [WordW-1:0]     out_value_q;
  logic [FillW-1:0]     out_lfill_q;
  logic [FillW-1:0]     out_min_q;

  logic                 clean;
  logic                 pop;
  logic                 load_out;
  logic [LayerIdxW-1:0] layer_idx;
  logic [FillW-1:0]     cur_fill;
  logic [FillW-1:0]     cap;
  logic [FillW:0]       sum_fill;
  logic [FillW:0]       slot_sum;
  logic [SlotW-1:0]     slot;
  logic [63:0]          row;
  logic [AddrW-1:0]     addr;
  lkv_status_e          status;
  logic                 wr_ok;
  logic                 rd_ok;
  logic                 commit;
  logic                 trunc_ok;
  logic [FillW-1:0]     lfill_after;
  logic                 scan_req;
  logic [WordW-1:0]     ram_key;
  logic [WordW-1:0]     ram_value;

  // Fill of the addressed layer and the effective capacity.
  assign layer_idx = LayerIdxW'(item_i.layer);
  assign cur_fill  = item_i.layer_ok ? fill_q[layer_idx] : '0;
  assign cap       = (32'(cfg_i.capacity) < 32'(MaxTokens)) ? cfg_i.capacity
                                                             : FillW'(MaxTokens);
  assign sum_fill  = {1'b0, cur_fill} + {1'b0, item_i.block};
  assign slot_sum  = {1'b0, cur_fill} + {2'b00, item_i.position};

  // Word address: layer, head, token slot, element.
  assign slot = (item_i.cmd == CMD_APPEND) ? SlotW'(slot_sum) : SlotW'(item_i.position);
  assign row  = 64'(item_i.layer) * 64'(MaxHeads) + 64'(item_i.head);
  assign addr = AddrW'((row * 64'(MaxTokens) + 64'(slot)) * 64'(MaxHeadDim)
                       + 64'(item_i.element));

  // Check the item at the head of the queue and decide its effect.
  always_comb begin
    status   = ST_OK;
    wr_ok    = 1'b0;
    rd_ok    = 1'b0;
    commit   = 1'b0;
    trunc_ok = 1'b0;
    case (item_i.cmd)
      CMD_APPEND: begin
        if (!item_i.layer_ok) begin
          status = ST_BAD_LAYER;
        end else if (sum_fill > {1'b0, cap}) begin
          status = ST_CAPACITY;
        end else if (!item_i.lane_ok || !item_i.pos_in_block) begin
          status = ST_BAD_INDEX;
        end else begin
          wr_ok  = 1'b1;
          commit = item_i.block_end;
        end
      end
      CMD_READ: begin
        if (!item_i.layer_ok) begin
          status = ST_BAD_LAYER;
        end else if (!item_i.lane_ok || ({1'b0, item_i.position} >= cur_fill)) begin
          status = ST_BAD_INDEX;
        end else begin
          rd_ok = 1'b1;
        end
      end
      CMD_TRUNCATE: begin
        if (item_i.target > min_q) begin
          status = ST_TRUNC_LONG;
        end else begin
          trunc_ok = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (!item_i.layer_ok) begin
          status = ST_BAD_LAYER;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    if (!item_i.layer_ok) begin
      lfill_after = '0;
    end else if (commit) begin
      lfill_after = sum_fill[FillW-1:0];
    end else if (trunc_ok) begin
      lfill_after = item_i.target;
    end else begin
      lfill_after = cur_fill;
    end
  end

  // Sequencer: dispatch one item, then load the result once the minimum is settled.
  assign clean = !dirty_q && !busy_q;

  always_comb begin
    state_d  = state_q;
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (item_valid_i && clean && !out_valid_q) begin
          pop     = 1'b1;
          state_d = BS_FINISH;
        end
      end
      BS_FINISH: begin
        if (clean) begin
          load_out = 1'b1;
          state_d  = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign item_pop_o = pop;
  assign scan_req   = (pop && commit) || cfg_layers_wr_i;

  // Running minimum over the active layers, one layer per cycle.
  assign acc_next = ((32'(idx_q) < 32'(cfg_i.layers)) && (fill_q[idx_q] < acc_q))
                    ? fill_q[idx_q] : acc_q;

  // Fill counters, minimum scan and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLayers; i++) begin
        fill_q[i] <= '0;
      end
      min_q       <= '0;
      dirty_q     <= 1'b0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (busy_q) begin
        acc_q <= acc_next;
        if (idx_q == LastIdx) begin
          busy_q <= 1'b0;
          min_q  <= (cfg_i.layers == '0) ? '0 : acc_next;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (dirty_q) begin
        dirty_q <= 1'b0;
        busy_q  <= 1'b1;
        idx_q   <= '0;
        acc_q   <= '1;
      end
      if (scan_req) begin
        dirty_q <= 1'b1;
      end

      if (pop && commit) begin
        fill_q[layer_idx] <= sum_fill[FillW-1:0];
      end
      if (pop && trunc_ok) begin
        for (int i = 0; i < MaxLayers; i++) begin
          fill_q[i] <= item_i.target;
        end
        min_q <= item_i.target;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending result fields and the output payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      pend_status_q <= status;
      pend_lfill_q  <= lfill_after;
      pend_read_q   <= rd_ok;
    end
    if (load_out) begin
      out_status_q <= pend_status_q;
      out_key_q    <= pend_read_q ? ram_key : '0;
      out_value_q  <= pend_read_q ? ram_value : '0;
      out_lfill_q  <= pend_lfill_q;
      out_min_q    <= min_q;
    end
  end

  // Key and value stores.
  lkv_ram #(
    .Width (WordW),
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (pop && wr_ok),
    .re_i    (pop && rd_ok),
    .addr_i  (addr),
    .wdata_i (item_i.key),
    .rdata_o (ram_key)
  );

  lkv_ram #(
    .Width (WordW),
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (pop && wr_ok),
    .re_i    (pop && rd_ok),
    .addr_i  (addr),
    .wdata_i (item_i.value),
    .rdata_o (ram_value)
  );

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_value_o  = out_value_q;
  assign out_lfill_o  = out_lfill_q;
  assign out_min_o    = out_min_q;

  a_pop_when_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (!dirty_q && !busy_q && !out_valid_q))
    else $error("item dispatched while minimum is stale or result is pending");

  a_pop_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |=> (state_q == BS_FINISH) && !out_valid_q)
    else $error("dispatch not followed by the finish state");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_FINISH) && !dirty_q && !busy_q |=> out_valid_q)
    else $error("settled item did not reach the output register");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == BS_FINISH))
    else $error("result appeared without a dispatched item");

endmodule

// ===== hdl/layered_kv_cache_store.sv =====
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tuser (command), tlast (block end)
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata, tuser (status)
// cfg       in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// The front end takes one beat per cycle into a two-entry queue while it has room.
// The back end handles one item at a time: it dispatches an item, then loads the result
// from its finish state, which picks up the registered read of the key/value memories.
// An append that closes a block, and a write to active_layers, start a minimum scan
// over the layers; the next result waits for it.
// A result in the output register holds the back end; a full queue then holds the front end.
// Reset clears the fill counters and the control state; the memories are not cleared.
module layered_kv_cache_store
  import lkv_pkg::*;
#(
  parameter int unsigned MaxLayers  = MaxLayersDef,
  parameter int unsigned MaxHeads   = MaxHeadsDef,
  parameter int unsigned MaxTokens  = MaxTokensDef,
  parameter int unsigned MaxHeadDim = MaxHeadDimDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // layer, block_tokens, position, head, element, key_word, value_word, target_length
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command
  input  logic [CmdW-1:0]     s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // key_out, value_out, layer_fill, min_fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [StatusW-1:0]  m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  lkv_cfg_t         cfg_q;
  logic             cfg_layers_wr;
  logic             push;
  lkv_item_t        front_item;
  lkv_item_t        queue_item;
  logic             queue_full;
  logic             queue_valid;
  logic             pop;
  logic [WordW-1:0] out_key;
  logic [WordW-1:0] out_value;
  logic [FillW-1:0] out_lfill;
  logic [FillW-1:0] out_min;

  // Configuration registers, always ready.
  assign cfg_ready_o   = 1'b1;
  assign cfg_layers_wr = cfg_valid_i && (lkv_cfg_idx_e'(cfg_index_i) == CFG_ACTIVE_LAYERS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layers   <= CfgLayersRst;
      cfg_q.heads    <= CfgHeadsRst;
      cfg_q.head_dim <= CfgHeadDimRst;
      cfg_q.capacity <= CfgCapacityRst;
    end else if (cfg_valid_i) begin
      case (lkv_cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE_LAYERS:   cfg_q.layers   <= cfg_data_i[2:0];
        CFG_ACTIVE_HEADS:    cfg_q.heads    <= cfg_data_i[2:0];
        CFG_ACTIVE_HEAD_DIM: cfg_q.head_dim <= cfg_data_i[6:0];
        CFG_TOKEN_CAPACITY:  cfg_q.capacity <= cfg_data_i[8:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  lkv_front #(
    .MaxLayers  (MaxLayers),
    .MaxHeads   (MaxHeads),
    .MaxHeadDim (MaxHeadDim)
  ) u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .cfg_i        (cfg_q),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  lkv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .item_o  (queue_item),
    .pop_i   (pop)
  );

  lkv_back #(
    .MaxLayers  (MaxLayers),
    .MaxHeads   (MaxHeads),
    .MaxTokens  (MaxTokens),
    .MaxHeadDim (MaxHeadDim)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cfg_layers_wr_i (cfg_layers_wr),
    .item_valid_i    (queue_valid),
    .item_i          (queue_item),
    .item_pop_o      (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_status_o    (m_axis_tuser),
    .out_key_o       (out_key),
    .out_value_o     (out_value),
    .out_lfill_o     (out_lfill),
    .out_min_o       (out_min)
  );

  // Pack the result beat, lowest field first.
  assign m_axis_tdata = {{OutPadW{1'b0}}, out_min, out_lfill, out_value, out_key};

endmodule

// ===== tb/layered_kv_cache_store_tb.sv =====
`timescale 1ns / 1ps

module layered_kv_cache_store_tb;
  import lkv_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ScanPause  = MaxLayersDef + 4;
  localparam int unsigned IdlePct    = 12;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned PhaseBeats = 86;
  localparam int unsigned SlotKeep   = 512;

  // One input beat, unpacked into its fields.
  typedef struct {
    lkv_cmd_e             cmd;
    logic [LayerW-1:0]    layer;
    logic [FillW-1:0]     block;
    logic [PosW-1:0]      pos;
    logic [HeadW-1:0]     head;
    logic [ElemW-1:0]     elem;
    logic [WordW-1:0]     key;
    logic [WordW-1:0]     val;
    logic                 last;
    logic [FillW-1:0]     target;
  } kv_beat_t;

  // One result beat, unpacked into its fields.
  typedef struct {
    lkv_status_e          status;
    logic [WordW-1:0]     key;
    logic [WordW-1:0]     val;
    logic [FillW-1:0]     layer_fill;
    logic [FillW-1:0]     min_fill;
  } kv_result_t;

  // A row of the directed table: either a register write or a stream beat.
  typedef struct {
    bit                   is_cfg;
    lkv_cfg_idx_e         idx;
    logic [CfgDataW-1:0]  data;
    kv_beat_t             beat;
    bit                   typed;
    kv_result_t           want;
  } kv_row_t;

  // A token slot that holds data, kept so that reads can be aimed at it.
  typedef struct {
    logic [LayerW-1:0]    layer;
    logic [HeadW-1:0]     head;
    logic [PosW-1:0]      slot;
    logic [ElemW-1:0]     elem;
  } kv_slot_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic [CmdW-1:0]     s_axis_tuser   = '0;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  // Shadow of the store: configuration, fill counters and written words.
  logic [2:0]          cfg_layers;
  logic [2:0]          cfg_heads;
  logic [6:0]          cfg_dim;
  logic [8:0]          cfg_cap;
  logic [FillW-1:0]    fill_cnt [MaxLayersDef];
  logic [WordW-1:0]    key_store [int unsigned];
  logic [WordW-1:0]    val_store [int unsigned];
  kv_slot_t            written_q [$];
  kv_result_t          result_q [$];

  int unsigned         fail_cnt     = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         beats_sent   = 0;
  bit                  calm         = 1'b0;

  // Register settings per random phase: layers, heads, head dim, capacity.
  int unsigned phase_cfg [NumPhases][4] = '{
    '{4, 4, 64, 256}, '{1, 1, 1, 1}, '{4, 2, 4, 16}, '{3, 4, 2, 8},
    '{4, 4, 8, 32}, '{7, 7, 127, 511}, '{2, 1, 64, 256}
  };

  layered_kv_cache_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // A register value limited to what the store is built for.
  function automatic int unsigned clamp_lim(int unsigned v, int unsigned lim);
    return (v < lim) ? v : lim;
  endfunction

  function automatic int unsigned slot_addr(int unsigned layer, int unsigned head,
                                            int unsigned slot, int unsigned elem);
    return ((layer * MaxHeadsDef + head) * MaxTokensDef + slot) * MaxHeadDimDef + elem;
  endfunction

  // Smallest fill over the layers in use, zero when none is in use.
  function automatic int unsigned lowest_fill();
    int unsigned n;
    int unsigned m;
    n = clamp_lim(cfg_layers, MaxLayersDef);
    m = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 || fill_cnt[i] < m) begin
        m = fill_cnt[i];
      end
    end
    return m;
  endfunction

  // Applies one beat to the shadow store and returns the result it should give.
  function automatic kv_result_t apply_beat(kv_beat_t b);
    int unsigned nl;
    int unsigned nh;
    int unsigned nd;
    int unsigned cap;
    int unsigned base;
    int unsigned a;
    bit          layer_ok;
    bit          lane_ok;
    kv_result_t  r;
    kv_slot_t    s;
    nl       = clamp_lim(cfg_layers, MaxLayersDef);
    nh       = clamp_lim(cfg_heads, MaxHeadsDef);
    nd       = clamp_lim(cfg_dim, MaxHeadDimDef);
    cap      = clamp_lim(cfg_cap, MaxTokensDef);
    layer_ok = b.layer < nl;
    lane_ok  = (b.head < nh) && (b.elem < nd);
    base     = fill_cnt[b.layer];
    r.status = ST_OK;
    r.key    = '0;
    r.val    = '0;
    case (b.cmd)
      CMD_APPEND: begin
        if (!layer_ok) begin
          r.status = ST_BAD_LAYER;
        end else if (base + b.block > cap) begin
          r.status = ST_CAPACITY;
        end else if (!lane_ok || b.pos >= b.block) begin
          r.status = ST_BAD_INDEX;
        end else begin
          a = slot_addr(b.layer, b.head, base + b.pos, b.elem);
          key_store[a] = b.key;
          val_store[a] = b.val;
          s.layer = b.layer;
          s.head  = b.head;
          s.slot  = base + b.pos;
          s.elem  = b.elem;
          written_q.push_back(s);
          if (written_q.size() > SlotKeep) begin
            void'(written_q.pop_front());
          end
          if (b.last) begin
            fill_cnt[b.layer] = base + b.block;
          end
        end
      end
      CMD_READ: begin
        if (!layer_ok) begin
          r.status = ST_BAD_LAYER;
        end else if (!lane_ok || b.pos >= base) begin
          r.status = ST_BAD_INDEX;
        end else begin
          a = slot_addr(b.layer, b.head, b.pos, b.elem);
          r.key = key_store[a];
          r.val = val_store[a];
        end
      end
      CMD_TRUNCATE: begin
        if (b.target > lowest_fill()) begin
          r.status = ST_TRUNC_LONG;
        end else begin
          for (int unsigned i = 0; i < MaxLayersDef; i++) begin
            fill_cnt[i] = b.target;
          end
        end
      end
      default: begin
        if (!layer_ok) begin
          r.status = ST_BAD_LAYER;
        end
      end
    endcase
    r.layer_fill = layer_ok ? fill_cnt[b.layer] : '0;
    r.min_fill   = lowest_fill();
    return r;
  endfunction

  // Directed table rows.
  function automatic kv_row_t beat_row(lkv_cmd_e cmd, int unsigned layer, int unsigned block,
                                       int unsigned pos, int unsigned head, int unsigned elem,
                                       logic [WordW-1:0] key, logic [WordW-1:0] val,
                                       bit last, int unsigned target);
    kv_row_t r;
    r.is_cfg      = 1'b0;
    r.typed       = 1'b0;
    r.beat.cmd    = cmd;
    r.beat.layer  = layer;
    r.beat.block  = block;
    r.beat.pos    = pos;
    r.beat.head   = head;
    r.beat.elem   = elem;
    r.beat.key    = key;
    r.beat.val    = val;
    r.beat.last   = last;
    r.beat.target = target;
    return r;
  endfunction

  function automatic kv_row_t typed_row(kv_row_t r, lkv_status_e st, int unsigned lf,
                                        int unsigned mf);
    r.typed           = 1'b1;
    r.want.status     = st;
    r.want.key        = '0;
    r.want.val        = '0;
    r.want.layer_fill = lf;
    r.want.min_fill   = mf;
    return r;
  endfunction

  function automatic kv_row_t reg_row(lkv_cfg_idx_e idx, int unsigned data);
    kv_row_t r;
    r.is_cfg = 1'b1;
    r.typed  = 1'b0;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  // A beat with every field random; callers then shape the fields that matter.
  function automatic kv_beat_t rand_beat();
    kv_beat_t b;
    b.cmd    = lkv_cmd_e'($urandom_range(3));
    b.layer  = $urandom_range(3);
    b.block  = $urandom_range(511);
    b.pos    = $urandom_range(255);
    b.head   = $urandom_range(3);
    b.elem   = $urandom_range(63);
    b.key    = $urandom;
    b.val    = $urandom;
    b.last   = $urandom_range(1);
    b.target = $urandom_range(511);
    return b;
  endfunction

  // An index below the active count, or anywhere in the field when none is active.
  function automatic int unsigned pick_below(int unsigned n, int unsigned full);
    return (n == 0) ? $urandom_range(full - 1) : $urandom_range(n - 1);
  endfunction

  // Predicts a beat, queues its result and drives it until the store takes it.
  task automatic issue(kv_beat_t b, bit typed, kv_result_t want);
    kv_result_t r;
    // A read of a slot below the fill that its block skipped is not defined,
    // so such a beat is turned into a length query.
    if (b.cmd == CMD_READ && b.layer < clamp_lim(cfg_layers, MaxLayersDef) &&
        b.head < clamp_lim(cfg_heads, MaxHeadsDef) &&
        b.elem < clamp_lim(cfg_dim, MaxHeadDimDef) && b.pos < fill_cnt[b.layer] &&
        !key_store.exists(slot_addr(b.layer, b.head, b.pos, b.elem))) begin
      b.cmd = CMD_QUERY;
    end
    r = apply_beat(b);
    result_q.push_back(typed ? want : r);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.cmd;
    s_axis_tlast  <= b.last;
    s_axis_tdata  <= {{InPadW{1'b0}}, b.target, b.val, b.key, b.elem, b.head, b.pos,
                      b.block, b.layer};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    beats_sent++;
  endtask

  // Register write, made only once the store has drained and finished its scan.
  task automatic write_reg(lkv_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (ScanPause) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ACTIVE_LAYERS:   cfg_layers = data[2:0];
      CFG_ACTIVE_HEADS:    cfg_heads  = data[2:0];
      CFG_ACTIVE_HEAD_DIM: cfg_dim    = data[6:0];
      default:             cfg_cap    = data[8:0];
    endcase
  endtask

  // A well-formed append block with random content, mostly committed at its end.
  task automatic run_block();
    kv_beat_t    b;
    kv_result_t  no_result;
    int unsigned nb;
    int unsigned lanes;
    int unsigned positions [$];
    bit          commit;
    b       = rand_beat();
    b.cmd   = CMD_APPEND;
    b.layer = pick_below(clamp_lim(cfg_layers, MaxLayersDef), MaxLayersDef);
    nb      = ($urandom_range(9) == 0) ? $urandom_range(256, 1) : $urandom_range(3, 1);
    b.block = nb;
    commit  = $urandom_range(99) < 85;
    if (nb <= 4) begin
      for (int unsigned p = 0; p < nb; p++) begin
        positions.push_back(p);
      end
    end else begin
      positions.push_back(0);
      positions.push_back(nb - 1);
    end
    foreach (positions[i]) begin
      lanes = $urandom_range(2, 1);
      for (int unsigned j = 0; j < lanes; j++) begin
        b.pos  = positions[i];
        b.head = pick_below(clamp_lim(cfg_heads, MaxHeadsDef), MaxHeadsDef);
        b.elem = pick_below(clamp_lim(cfg_dim, MaxHeadDimDef), MaxHeadDimDef);
        b.key  = $urandom;
        b.val  = $urandom;
        b.last = commit && (i == positions.size() - 1) && (j == lanes - 1);
        issue(b, 1'b0, no_result);
      end
    end
  endtask

  // The result side stalls at random, except through the calm phase.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Compares each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    kv_result_t got;
    kv_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = lkv_status_e'(m_axis_tuser);
      got.key        = m_axis_tdata[WordW-1:0];
      got.val        = m_axis_tdata[2*WordW-1:WordW];
      got.layer_fill = m_axis_tdata[2*WordW+FillW-1:2*WordW];
      got.min_fill   = m_axis_tdata[2*WordW+2*FillW-1:2*WordW+FillW];
      if (result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ReportMax) begin
          $display("unexpected result beat: status %0d fill %0d min %0d",
                   m_axis_tuser, got.layer_fill, got.min_fill);
        end
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status || got.key !== want.key || got.val !== want.val ||
            got.layer_fill !== want.layer_fill || got.min_fill !== want.min_fill) begin
          fail_cnt++;
          if (fail_cnt <= ReportMax) begin
            $display("result mismatch: want st %0d key %h val %h fill %0d min %0d",
                     want.status, want.key, want.val, want.layer_fill, want.min_fill);
            $display("                  got st %0d key %h val %h fill %0d min %0d",
                     got.status, got.key, got.val, got.layer_fill, got.min_fill);
          end
        end
      end
    end
  end

  // Ends the run when no beat has moved on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    kv_row_t     dir_q [$];
    kv_beat_t    b;
    kv_result_t  no_result;
    kv_slot_t    s;
    int unsigned phase_end;
    int unsigned pick;

    // Shadow state after reset.
    cfg_layers = CfgLayersRst;
    cfg_heads  = CfgHeadsRst;
    cfg_dim    = CfgHeadDimRst;
    cfg_cap    = CfgCapacityRst;
    for (int unsigned i = 0; i < MaxLayersDef; i++) begin
      fill_cnt[i] = '0;
    end

    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty store, length and index extremes, every error code,
    // truncation limits, an inactive layer and zero registers.
    dir_q.push_back(typed_row(beat_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                              ST_BAD_INDEX, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 0, 0, 0, 0, 0, '1, '1, 1, 0),
                              ST_BAD_INDEX, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 0, 511, 0, 0, 0, '1, '1, 1, 0),
                              ST_CAPACITY, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 3, 257, 0, 0, 0, 0, 0, 1, 511),
                              ST_CAPACITY, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_TRUNCATE, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                              ST_TRUNC_LONG, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_TRUNCATE, 2, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 0, 0));
    dir_q.push_back(beat_row(CMD_APPEND, 0, 2, 0, 3, 63, 32'hFFFF_FFFF, 32'h0, 0, 0));
    dir_q.push_back(beat_row(CMD_APPEND, 0, 2, 1, 3, 63, 32'h0, 32'hFFFF_FFFF, 1, 0));
    dir_q.push_back(beat_row(CMD_READ, 0, 0, 1, 3, 63, 0, 0, 0, 0));
    dir_q.push_back(beat_row(CMD_READ, 0, 0, 0, 3, 63, 0, 0, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_READ, 0, 0, 2, 3, 63, 0, 0, 0, 0),
                              ST_BAD_INDEX, 2, 0));
    dir_q.push_back(beat_row(CMD_APPEND, 1, 256, 255, 0, 0, 32'h1234_5678, 32'h9ABC_DEF0, 1, 0));
    dir_q.push_back(beat_row(CMD_APPEND, 2, 256, 255, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 0));
    dir_q.push_back(beat_row(CMD_APPEND, 3, 256, 255, 0, 0, 32'h8000_0001, 32'h7FFF_FFFE, 1, 0));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 1, 1, 0, 0, 0, 0, 0, 1, 0),
                              ST_CAPACITY, 256, 2));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 0, 5, 5, 0, 0, 0, 0, 1, 0),
                              ST_BAD_INDEX, 2, 2));
    dir_q.push_back(typed_row(beat_row(CMD_TRUNCATE, 1, 0, 0, 0, 0, 0, 0, 0, 3),
                              ST_TRUNC_LONG, 256, 2));
    dir_q.push_back(typed_row(beat_row(CMD_TRUNCATE, 3, 0, 0, 0, 0, 0, 0, 0, 2), ST_OK, 2, 2));
    dir_q.push_back(reg_row(CFG_ACTIVE_LAYERS, 1));
    dir_q.push_back(typed_row(beat_row(CMD_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0),
                              ST_BAD_LAYER, 0, 2));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 2, 1, 0, 0, 0, 0, 0, 1, 0),
                              ST_BAD_LAYER, 0, 2));
    dir_q.push_back(reg_row(CFG_ACTIVE_HEADS, 1));
    dir_q.push_back(reg_row(CFG_ACTIVE_HEAD_DIM, 1));
    dir_q.push_back(typed_row(beat_row(CMD_READ, 0, 0, 0, 3, 63, 0, 0, 0, 0),
                              ST_BAD_INDEX, 2, 2));
    dir_q.push_back(reg_row(CFG_TOKEN_CAPACITY, 0));
    dir_q.push_back(typed_row(beat_row(CMD_APPEND, 0, 1, 0, 0, 0, 0, 0, 1, 0),
                              ST_CAPACITY, 2, 2));
    dir_q.push_back(reg_row(CFG_ACTIVE_LAYERS, 0));
    dir_q.push_back(typed_row(beat_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                              ST_BAD_LAYER, 0, 0));
    dir_q.push_back(typed_row(beat_row(CMD_TRUNCATE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                              ST_BAD_LAYER == ST_BAD_LAYER ? ST_OK : ST_OK, 0, 0));

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        write_reg(dir_q[i].idx, dir_q[i].data);
      end else begin
        issue(dir_q[i].beat, dir_q[i].typed, dir_q[i].want);
      end
    end

    // Random part: one register setting per phase, each phase opened by a
    // truncate to zero so that blocks have room again.
    phase_cfg[4][0] = $urandom_range(4, 1);
    phase_cfg[4][1] = $urandom_range(4, 1);
    phase_cfg[4][2] = $urandom_range(8, 1);
    phase_cfg[4][3] = $urandom_range(32, 1);
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      for (int unsigned k = 0; k < 4; k++) begin
        write_reg(lkv_cfg_idx_e'(k), phase_cfg[ph][k]);
      end
      calm      = (ph == 3);
      phase_end = beats_sent + PhaseBeats;
      b         = rand_beat();
      b.cmd     = CMD_TRUNCATE;
      b.target  = 0;
      issue(b, 1'b0, no_result);
      while (beats_sent < phase_end) begin
        pick = $urandom_range(99);
        b    = rand_beat();
        if (pick < 40) begin
          run_block();
        end else begin
          if (pick < 65) begin
            // Reads aimed mostly at slots known to hold data.
            b.cmd = CMD_QUERY;
            if (written_q.size() != 0) begin
              s       = written_q[$urandom_range(written_q.size() - 1)];
              b.cmd   = CMD_READ;
              b.layer = s.layer;
              b.head  = s.head;
              b.pos   = s.slot;
              b.elem  = s.elem;
            end
          end else if (pick < 72) begin
            b.cmd = CMD_TRUNCATE;
            if ($urandom_range(9) != 0) begin
              b.target = $urandom_range(lowest_fill() + 1);
            end
          end else if (pick < 78) begin
            b.cmd = CMD_QUERY;
          end
          issue(b, 1'b0, no_result);
        end
      end
    end
    calm = 1'b0;

    // Drain, then let the store settle before the verdict.
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2 * ScanPause) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
